// File: rtl/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/itrs_pkg.sv
// types, constants and helpers for the integer to radix string converter
`default_nettype none

package itrs_pkg;

    localparam int MAX_DIGITS    = 32;
    localparam int MAX_BASE      = 16;
    localparam int DATA_W        = 32;
    localparam int DIGIT_W       = 4;
    localparam int BASE_W        = 5;
    localparam int CHAR_W        = 8;
    localparam int SYM_W         = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int ADDR_W        = $clog2(MAX_DIGITS);
    localparam int CNT_W         = $clog2(MAX_DIGITS + 1);
    localparam int BITS_PER_STEP = 4;
    localparam int DIV_STEPS     = DATA_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(DIV_STEPS);

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

    localparam logic [BASE_W-1:0] BASE_RESET   = 5'd10;
    localparam logic [SYM_W-1:0]  SYM_LO_RESET = 64'd3978425819141910832;
    localparam logic [SYM_W-1:0]  SYM_HI_RESET = 64'd7378413942531504440;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_RD,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic ld_sign;
        logic rd_digit;
        logic ld_digit;
    } t_cmd;

    typedef struct packed {
        logic digit_done;
        logic more;
        logic neg;
        logic out_free;
        logic last_digit;
    } t_status;

    function automatic logic [CHAR_W-1:0] symbol_for(
        input logic [DIGIT_W-1:0] digit,
        input logic [SYM_W-1:0]   lo,
        input logic [SYM_W-1:0]   hi
    );
        logic [SYM_W-1:0] word;
        word = digit[DIGIT_W-1] ? hi : lo;
        return word[digit[DIGIT_W-2:0] * CHAR_W +: CHAR_W];
    endfunction

endpackage

`default_nettype wire

// File: rtl/itrs_ram.sv
// generic single write port ram with registered read
`default_nettype none

module itrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/itrs_ctrl.sv
// controller state machine for the radix string converter
`default_nettype none

module itrs_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire itrs_pkg::t_status i_status,
    output logic                  o_in_stall,
    output itrs_pkg::t_cmd        o_cmd
);

    itrs_pkg::t_state r_state;
    itrs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itrs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            itrs_pkg::S_IDLE: begin
                if (i_in_valid) n_state = itrs_pkg::S_DIV;
            end
            itrs_pkg::S_DIV: begin
                if (i_status.digit_done && !i_status.more) begin
                    n_state = i_status.neg ? itrs_pkg::S_SIGN : itrs_pkg::S_RD;
                end
            end
            itrs_pkg::S_SIGN: begin
                if (i_status.out_free) n_state = itrs_pkg::S_RD;
            end
            itrs_pkg::S_RD: begin
                n_state = itrs_pkg::S_LOAD;
            end
            itrs_pkg::S_LOAD: begin
                if (i_status.out_free) begin
                    n_state = i_status.last_digit ? itrs_pkg::S_IDLE : itrs_pkg::S_RD;
                end
            end
            default: n_state = itrs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            itrs_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            itrs_pkg::S_DIV:  o_cmd.div_step = 1'b1;
            itrs_pkg::S_SIGN: o_cmd.ld_sign  = i_status.out_free;
            itrs_pkg::S_RD:   o_cmd.rd_digit = 1'b1;
            itrs_pkg::S_LOAD: o_cmd.ld_digit = i_status.out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/itrs_datapath.sv
// datapath: config registers, digit divider, digit store and output register
`default_nettype none

module itrs_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [itrs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [itrs_pkg::SYM_W-1:0]      i_cfg_data,
    input  wire logic signed [itrs_pkg::DATA_W-1:0] i_value,
    input  wire logic                            i_out_stall,
    input  wire itrs_pkg::t_cmd                  i_cmd,
    output itrs_pkg::t_status                    o_status,
    output logic                                 o_out_valid,
    output logic [itrs_pkg::CHAR_W-1:0]          o_out_char,
    output logic                                 o_last
);

    logic [itrs_pkg::BASE_W-1:0]  r_base_size;
    logic [itrs_pkg::SYM_W-1:0]   r_sym_lo;
    logic [itrs_pkg::SYM_W-1:0]   r_sym_hi;
    logic [itrs_pkg::DATA_W-1:0]  r_a;
    logic [itrs_pkg::DIGIT_W-1:0] r_rem;
    logic [itrs_pkg::STEP_W-1:0]  r_step;
    logic [itrs_pkg::CNT_W-1:0]   r_count;
    logic                         r_neg;
    logic                         r_out_valid;
    logic [itrs_pkg::CHAR_W-1:0]  r_out_char;
    logic                         r_out_last;

    logic [itrs_pkg::BASE_W-1:0]  eff_base;
    logic [itrs_pkg::DATA_W-1:0]  div_a;
    logic [itrs_pkg::DIGIT_W-1:0] div_rem;
    logic [itrs_pkg::BASE_W-1:0]  div_sh;
    logic                         digit_done;
    logic                         ram_we;
    logic [itrs_pkg::ADDR_W-1:0]  ram_raddr;
    logic [itrs_pkg::DIGIT_W-1:0] ram_rdata;
    logic [itrs_pkg::DATA_W-1:0]  in_mag;

    always_comb begin
        if (r_base_size < itrs_pkg::BASE_W'(2)) begin
            eff_base = itrs_pkg::BASE_W'(2);
        end else if (r_base_size > itrs_pkg::BASE_W'(itrs_pkg::MAX_BASE)) begin
            eff_base = itrs_pkg::BASE_W'(itrs_pkg::MAX_BASE);
        end else begin
            eff_base = r_base_size;
        end
    end

    // restoring division, BITS_PER_STEP quotient bits at a time, remainder stays below base
    always_comb begin
        div_a   = r_a;
        div_rem = r_rem;
        div_sh  = '0;
        for (int i = 0; i < itrs_pkg::BITS_PER_STEP; i++) begin
            div_sh = {div_rem, div_a[itrs_pkg::DATA_W-1]};
            div_a  = {div_a[itrs_pkg::DATA_W-2:0], 1'b0};
            if (div_sh >= eff_base) begin
                div_sh   = div_sh - eff_base;
                div_a[0] = 1'b1;
            end
            div_rem = div_sh[itrs_pkg::DIGIT_W-1:0];
        end
    end

    assign in_mag     = i_value[itrs_pkg::DATA_W-1] ?
                        (itrs_pkg::DATA_W'(0) - $unsigned(i_value)) : $unsigned(i_value);
    assign digit_done = (r_step == itrs_pkg::STEP_W'(itrs_pkg::DIV_STEPS - 1));
    assign ram_we     = i_cmd.div_step && digit_done;
    assign ram_raddr  = itrs_pkg::ADDR_W'(r_count - itrs_pkg::CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_size <= itrs_pkg::BASE_RESET;
            r_sym_lo    <= itrs_pkg::SYM_LO_RESET;
            r_sym_hi    <= itrs_pkg::SYM_HI_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                itrs_pkg::REG_BASE_SIZE:    r_base_size <= i_cfg_data[itrs_pkg::BASE_W-1:0];
                itrs_pkg::REG_SYMBOLS_LOW:  r_sym_lo    <= i_cfg_data;
                itrs_pkg::REG_SYMBOLS_HIGH: r_sym_hi    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a         <= '0;
            r_rem       <= '0;
            r_step      <= '0;
            r_count     <= '0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_a     <= in_mag;
                r_neg   <= i_value[itrs_pkg::DATA_W-1];
                r_rem   <= '0;
                r_step  <= '0;
                r_count <= '0;
            end else if (i_cmd.div_step) begin
                r_a    <= div_a;
                r_step <= r_step + itrs_pkg::STEP_W'(1);
                if (digit_done) begin
                    r_rem   <= '0;
                    r_count <= r_count + itrs_pkg::CNT_W'(1);
                end else begin
                    r_rem <= div_rem;
                end
            end else if (i_cmd.ld_digit) begin
                r_count <= r_count - itrs_pkg::CNT_W'(1);
            end

            if (i_cmd.ld_sign || i_cmd.ld_digit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_sign) begin
            r_out_char <= itrs_pkg::MINUS_CHAR;
            r_out_last <= 1'b0;
        end else if (i_cmd.ld_digit) begin
            r_out_char <= itrs_pkg::symbol_for(ram_rdata, r_sym_lo, r_sym_hi);
            r_out_last <= (r_count == itrs_pkg::CNT_W'(1));
        end
    end

    itrs_ram #(
        .WIDTH (itrs_pkg::DIGIT_W),
        .DEPTH (itrs_pkg::MAX_DIGITS)
    ) u_digit_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[itrs_pkg::ADDR_W-1:0]),
        .i_wdata (div_rem),
        .i_re    (i_cmd.rd_digit),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_status.digit_done = digit_done;
    assign o_status.more       = (div_a != '0) &&
                                 (r_count != itrs_pkg::CNT_W'(itrs_pkg::MAX_DIGITS - 1));
    assign o_status.neg        = r_neg;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;
    assign o_status.last_digit = (r_count == itrs_pkg::CNT_W'(1));

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

// File: rtl/integer_to_radix_string.sv
// top level of the integer to radix string converter
`default_nettype none
`include "assert_macros.svh"

// Converts one signed 32-bit value per item into its text in base 2..16
// (base_size clamped into that range), one output item per character: a
// leading '-' for negative values, then the digit symbols most significant
// first, with o_last high on the final character. The divider retires 4
// quotient bits per cycle against the base, one digit after another; each
// digit is then emitted by a digit store read, then an output load; the
// output load, like the load of a sign, waits while the output is stalled.
// A new item is taken once the last character has been loaded into the
// output register. Configuration writes are always ready and must only be
// made while the block is idle.
module integer_to_radix_string (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic signed [itrs_pkg::DATA_W-1:0] i_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [itrs_pkg::CHAR_W-1:0]             o_out_char,
    output logic                                    o_last,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [itrs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [itrs_pkg::SYM_W-1:0]         i_cfg_data
);

    itrs_pkg::t_cmd    cmd;
    itrs_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    itrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    itrs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_value     (i_value),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_char  (o_out_char),
        .o_last      (o_last)
    );

    // an accepted item keeps the input stalled while it is converted
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // a character is never loaded over one still waiting to be taken
    `ASSERT_ALWAYS(a_no_overwrite, i_clk, i_rst_n,
        !(cmd.ld_sign || cmd.ld_digit) || status.out_free)
    // the divider stops once the final digit is stored
    `ASSERT_NEXT(a_div_stops, i_clk, i_rst_n,
        cmd.div_step && status.digit_done && !status.more, !cmd.div_step)

endmodule

`default_nettype wire

// File: tb/itrs_checker.sv
// checker for the integer to radix string converter: predicts the text of each value and compares
`timescale 1ns / 1ps

module itrs_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    input  wire logic                             i_in_stall,
    input  wire logic [itrs_pkg::DATA_W-1:0]      i_value,
    input  wire logic                             i_out_valid,
    input  wire logic                             i_out_stall,
    input  wire logic [itrs_pkg::CHAR_W-1:0]      i_out_char,
    input  wire logic                             i_last,
    input  wire logic                             i_cfg_valid,
    input  wire logic                             i_cfg_ready,
    input  wire logic [itrs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [itrs_pkg::SYM_W-1:0]       i_cfg_data,
    output int                                    o_fail_count,
    output int                                    o_pending
);

    typedef struct packed {
        logic [itrs_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } t_text_char;

    t_text_char                  expected_text [$];
    logic [itrs_pkg::BASE_W-1:0] base_reg;
    logic [itrs_pkg::SYM_W-1:0]  sym_lo;
    logic [itrs_pkg::SYM_W-1:0]  sym_hi;
    int                          mismatches = 0;

    // queue the characters that one value turns into under the current settings
    task automatic predict_text(input logic [itrs_pkg::DATA_W-1:0] raw);
        logic [itrs_pkg::DATA_W-1:0]  mag;
        logic [itrs_pkg::DIGIT_W-1:0] digits [itrs_pkg::MAX_DIGITS];
        logic [itrs_pkg::DIGIT_W-1:0] dig;
        logic [itrs_pkg::SYM_W-1:0]   word;
        int unsigned                  radix;
        int                           ndig;
        if (base_reg < itrs_pkg::BASE_W'(2))
            radix = 2;
        else if (base_reg > itrs_pkg::BASE_W'(itrs_pkg::MAX_BASE))
            radix = itrs_pkg::MAX_BASE;
        else
            radix = 32'(base_reg);
        // magnitude as unsigned, so the most negative value survives
        mag = raw[itrs_pkg::DATA_W-1] ? -raw : raw;
        ndig = 0;
        do begin
            digits[ndig[itrs_pkg::ADDR_W-1:0]] = itrs_pkg::DIGIT_W'(mag % radix);
            mag = mag / radix;
            ndig++;
        end while (mag != 0 && ndig < itrs_pkg::MAX_DIGITS);
        if (raw[itrs_pkg::DATA_W-1])
            expected_text.push_back({itrs_pkg::MINUS_CHAR, 1'b0});
        for (int k = ndig - 1; k >= 0; k--) begin
            dig  = digits[k[itrs_pkg::ADDR_W-1:0]];
            word = dig[itrs_pkg::DIGIT_W-1] ? sym_hi : sym_lo;
            expected_text.push_back(
                {word[itrs_pkg::CHAR_W * dig[itrs_pkg::DIGIT_W-2:0] +: itrs_pkg::CHAR_W],
                 k == 0});
        end
    endtask

    always @(posedge i_clk) begin
        t_text_char got;
        t_text_char want;
        if (!i_rst_n) begin
            base_reg = itrs_pkg::BASE_RESET;
            sym_lo   = itrs_pkg::SYM_LO_RESET;
            sym_hi   = itrs_pkg::SYM_HI_RESET;
            expected_text.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    itrs_pkg::REG_BASE_SIZE:    base_reg = i_cfg_data[itrs_pkg::BASE_W-1:0];
                    itrs_pkg::REG_SYMBOLS_LOW:  sym_lo = i_cfg_data;
                    itrs_pkg::REG_SYMBOLS_HIGH: sym_hi = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                predict_text(i_value);
            if (i_out_valid && !i_out_stall) begin
                got = {i_out_char, i_last};
                if (expected_text.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected char %h last %b", $realtime, i_out_char,
                                 i_last);
                end else begin
                    want = expected_text.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected char %h last %b, got char %h last %b",
                                     $realtime, want.ch, want.last, got.ch, got.last);
                    end
                end
            end
        end
        o_pending    <= expected_text.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: tb/testbench.sv
// top of the testbench for the integer to radix string converter: stimulus and verdict
`timescale 1ns / 1ps

module testbench;

    // index that selects no register
    localparam logic [itrs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n;
    logic                                  i_in_valid;
    logic                                  o_in_stall;
    logic signed [itrs_pkg::DATA_W-1:0]    i_value;
    logic                                  o_out_valid;
    logic                                  i_out_stall = 1'b0;
    logic [itrs_pkg::CHAR_W-1:0]           o_out_char;
    logic                                  o_last;
    logic                                  i_cfg_valid;
    logic                                  o_cfg_ready;
    logic [itrs_pkg::CFG_IDX_W-1:0]        i_cfg_index;
    logic [itrs_pkg::SYM_W-1:0]            i_cfg_data;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    integer_to_radix_string u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_char  (o_out_char),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    itrs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_char   (o_out_char),
        .i_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_value(input logic [itrs_pkg::DATA_W-1:0] v);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [itrs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [itrs_pkg::SYM_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // hold the sender back until every character of every value has come out
    task automatic wait_text_drained();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // junk in the unused upper bits of the base write must be ignored
    task automatic apply_setting(input logic [itrs_pkg::BASE_W-1:0] base,
                                 input logic [itrs_pkg::SYM_W-1:0] lo,
                                 input logic [itrs_pkg::SYM_W-1:0] hi, input bit poke_unused);
        write_reg(itrs_pkg::REG_BASE_SIZE, {$urandom, 27'($urandom), base});
        write_reg(itrs_pkg::REG_SYMBOLS_LOW, lo);
        write_reg(itrs_pkg::REG_SYMBOLS_HIGH, hi);
        if (poke_unused)
            write_reg(REG_UNUSED, {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [itrs_pkg::DATA_W-1:0] pick_value();
        logic [itrs_pkg::DATA_W-1:0] v;
        case ($urandom_range(4))
            0, 1: v = $urandom;
            2: v = $urandom >> $urandom_range(31);
            3: v = -($urandom >> $urandom_range(31));
            default: begin
                case ($urandom_range(4))
                    0: v = '0;
                    1: v = '1;
                    2: v = 32'h7FFF_FFFF;
                    3: v = 32'h8000_0000;
                    default: v = 32'd1;
                endcase
            end
        endcase
        return v;
    endfunction

    initial begin
        logic [itrs_pkg::SYM_W-1:0] lo;
        logic [itrs_pkg::SYM_W-1:0] hi;
        logic [itrs_pkg::BASE_W-1:0] base;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_value     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = itrs_pkg::REG_BASE_SIZE;
        i_cfg_data  = '0;
        send_idle_pct  = 26;
        recv_stall_pct = 69;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // decimal with the settings out of reset
        send_value(32'd0);
        send_value(32'd7);
        send_value(-32'sd5);
        send_value(32'd10);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value('1);
        send_value(32'd1_000_000_000);
        wait_text_drained();

        apply_setting(5'd16, itrs_pkg::SYM_LO_RESET, itrs_pkg::SYM_HI_RESET, 1'b1);
        send_value('1);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'hFEDC_BA98);
        send_value(32'h0F0F_0F0F);
        wait_text_drained();

        // binary: the most negative value gives the longest text
        apply_setting(5'd2, itrs_pkg::SYM_LO_RESET, itrs_pkg::SYM_HI_RESET, 1'b0);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd1);
        send_value(32'd0);
        send_value(-32'sd2);
        wait_text_drained();

        // base sizes outside 2..16 get clamped
        apply_setting(5'd0, itrs_pkg::SYM_LO_RESET, itrs_pkg::SYM_HI_RESET, 1'b0);
        send_value(32'd5);
        wait_text_drained();
        apply_setting(5'd1, itrs_pkg::SYM_LO_RESET, itrs_pkg::SYM_HI_RESET, 1'b0);
        send_value(-32'sd6);
        wait_text_drained();
        apply_setting(5'd31, itrs_pkg::SYM_LO_RESET, itrs_pkg::SYM_HI_RESET, 1'b0);
        send_value(32'd255);
        wait_text_drained();
        apply_setting(5'd17, itrs_pkg::SYM_LO_RESET, itrs_pkg::SYM_HI_RESET, 1'b0);
        send_value(32'd16);
        wait_text_drained();

        for (int g = 0; g < 10; g++) begin
            if (g < 4) begin
                send_idle_pct = 26;
                recv_stall_pct <= 69;
            end else if (g < 7) begin
                send_idle_pct = 69;
                recv_stall_pct <= 26;
            end else begin
                send_idle_pct = 0;
                recv_stall_pct <= 0;
            end
            case ($urandom_range(3))
                0: base = 5'($urandom_range(31));
                1: base = 5'($urandom_range(2, 16));
                2: base = $urandom_range(1) ? 5'd2 : 5'd16;
                default: base = 5'd10;
            endcase
            if (g == 0) begin
                lo = '0;
                hi = '0;
            end else if (g == 1) begin
                lo = '1;
                hi = '1;
            end else if ($urandom_range(2) == 0) begin
                lo = itrs_pkg::SYM_LO_RESET;
                hi = itrs_pkg::SYM_HI_RESET;
            end else begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
            end
            apply_setting(base, lo, hi, 1'($urandom_range(1)));
            repeat (25) send_value(pick_value());
            wait_text_drained();
        end

        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/itrs_pkg.sv
rtl/itrs_ram.sv
rtl/itrs_ctrl.sv
rtl/itrs_datapath.sv
rtl/integer_to_radix_string.sv
tb/itrs_checker.sv
tb/testbench.sv
